// ----- sv/rsr_pkg.sv -----
package rsr_pkg;

  localparam int DATA_W           = 11;
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int ACTIVE_RESET     = 1024;

  // controller -> datapath
  typedef struct packed {
    logic refill;    // word is a refill: latch size, start clearing
    logic reject;    // word is a bad select: flag error
    logic start;     // word is a good select: start descent at root
    logic step;      // descend one level
    logic clear;     // write one zero entry of the tree memory
    logic load_out;  // move result into the output register
  } rsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rank_bad;
    logic last_level;
    logic clr_last;
  } rsr_status_t;

endpackage

// ----- sv/rsr_datapath.sv -----
module rsr_datapath #(
  parameter int MaxPositions = rsr_pkg::MAX_POSITIONS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [rsr_pkg::DATA_W-1:0] cfg_data_i,
  input  logic [rsr_pkg::DATA_W-1:0] rank_i,
  input  rsr_pkg::rsr_cmd_t         cmd_i,
  output rsr_pkg::rsr_status_t      status_o,
  output logic [rsr_pkg::DATA_W-1:0] position_o,
  output logic                      error_o,
  output logic [rsr_pkg::DATA_W-1:0] remaining_o
);
  import rsr_pkg::*;

  localparam int LB   = $clog2(MaxPositions);
  localparam int L    = 1 << LB;
  localparam int NW   = LB + 1;
  localparam int CW   = (LB + 2 > 12) ? LB + 2 : 12;
  localparam int LVW  = $clog2(LB + 1);
  localparam int RESET_SIZE = (MaxPositions < ACTIVE_RESET) ? MaxPositions : ACTIVE_RESET;

  // removed-position count per tree node; root is implied by remaining count
  logic [NW-1:0] mem [2*L];

  logic [DATA_W-1:0] active_q;
  logic [DATA_W-1:0] tsize_q, tsize_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [NW-1:0]     node_q, node_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     span_q, span_d;
  logic [LVW-1:0]    level_q, level_d;
  logic [DATA_W-1:0] want_q, want_d;
  logic [NW-1:0]     clr_q, clr_d;
  logic [NW-1:0]     rd_l_q, rd_r_q;
  logic [DATA_W-1:0] res_pos_q, res_pos_d;
  logic              res_err_q, res_err_d;
  logic [DATA_W-1:0] out_pos_q;
  logic              out_err_q;
  logic [DATA_W-1:0] out_rem_q;

  logic [DATA_W-1:0] clamp_size;
  logic [CW-1:0]     ts_ext, want_ext, left_cov, left_pres, span_cov, pick_lo;
  logic              go_left;
  logic [NW-1:0]     wr_idx;
  logic [NW-1:0]     wr_data;
  logic              wr_en;
  logic [NW-1:0]     rd_l_idx, rd_r_idx;

  always_comb begin
    if (32'(active_q) > 32'(MaxPositions)) begin
      clamp_size = DATA_W'(MaxPositions);
    end else begin
      clamp_size = active_q;
    end
  end

  // left child's present count: positions in its span that lie in 1..tree_size, less removed
  always_comb begin
    ts_ext    = CW'(tsize_q);
    want_ext  = CW'(want_q);
    span_cov  = ts_ext - lo_q + CW'(1);
    if (ts_ext < lo_q) begin
      left_cov = '0;
    end else if (span_cov > span_q) begin
      left_cov = span_q;
    end else begin
      left_cov = span_cov;
    end
    left_pres = left_cov - CW'(rd_l_q);
    go_left   = (left_pres >= want_ext);
    pick_lo   = go_left ? lo_q : lo_q + span_q;
  end

  assign status_o.rank_bad   = (rank_i == '0) || (rank_i > rem_q);
  assign status_o.last_level = (level_q == LVW'(LB - 1));
  assign status_o.clr_last   = (clr_q == {NW{1'b1}});

  always_comb begin
    tsize_d   = tsize_q;
    rem_d     = rem_q;
    node_d    = node_q;
    lo_d      = lo_q;
    span_d    = span_q;
    level_d   = level_q;
    want_d    = want_q;
    clr_d     = clr_q;
    res_pos_d = res_pos_q;
    res_err_d = res_err_q;
    wr_en     = 1'b0;
    wr_idx    = clr_q;
    wr_data   = '0;
    if (cmd_i.refill) begin
      tsize_d   = clamp_size;
      rem_d     = clamp_size;
      clr_d     = '0;
      res_pos_d = '0;
      res_err_d = 1'b0;
    end
    if (cmd_i.reject) begin
      res_pos_d = '0;
      res_err_d = 1'b1;
    end
    if (cmd_i.start) begin
      node_d    = NW'(1);
      lo_d      = CW'(1);
      span_d    = CW'(L / 2);
      level_d   = '0;
      want_d    = rank_i;
      res_err_d = 1'b0;
    end
    if (cmd_i.step) begin
      wr_en   = 1'b1;
      wr_idx  = {node_q[NW-2:0], ~go_left};
      wr_data = (go_left ? rd_l_q : rd_r_q) + NW'(1);
      node_d  = {node_q[NW-2:0], ~go_left};
      lo_d    = pick_lo;
      span_d  = span_q >> 1;
      level_d = level_q + LVW'(1);
      if (!go_left) begin
        want_d = want_q - DATA_W'(left_pres);
      end
      if (status_o.last_level) begin
        res_pos_d = DATA_W'(pick_lo);
        rem_d     = rem_q - DATA_W'(1);
      end
    end
    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_idx  = clr_q;
      wr_data = '0;
      clr_d   = clr_q + NW'(1);
    end
  end

  // children of the node being entered; leaf children wrap and are never used
  assign rd_l_idx = {node_d[NW-2:0], 1'b0};
  assign rd_r_idx = {node_d[NW-2:0], 1'b1};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_l_q <= mem[rd_l_idx];
    rd_r_q <= mem[rd_r_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= DATA_W'(ACTIVE_RESET);
      tsize_q  <= DATA_W'(RESET_SIZE);
      rem_q    <= DATA_W'(RESET_SIZE);
      clr_q    <= '0;
      level_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        active_q <= cfg_data_i;
      end
      tsize_q <= tsize_d;
      rem_q   <= rem_d;
      clr_q   <= clr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    lo_q      <= lo_d;
    span_q    <= span_d;
    want_q    <= want_d;
    res_pos_q <= res_pos_d;
    res_err_q <= res_err_d;
    if (cmd_i.load_out) begin
      out_pos_q <= res_pos_q;
      out_err_q <= res_err_q;
      out_rem_q <= rem_q;
    end
  end

  assign position_o  = out_pos_q;
  assign error_o     = out_err_q;
  assign remaining_o = out_rem_q;

endmodule

// ----- sv/rsr_ctrl.sv -----
module rsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rsr_pkg::rsr_status_t status_i,
  output rsr_pkg::rsr_cmd_t    cmd_o
);
  import rsr_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   refill_q, refill_d;   // clear pass belongs to a refill word, not reset
  logic   ovalid_q, ovalid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    refill_d = refill_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = refill_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!func_i) begin
            cmd_o.refill = 1'b1;
            refill_d     = 1'b1;
            state_d      = S_CLEAR;
          end else if (status_i.rank_bad) begin
            cmd_o.reject = 1'b1;
            state_d      = S_DONE;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.last_level) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      refill_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      refill_q <= refill_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- sv/rank_select_and_remove_unit.sv -----
// Rank select and remove over positions 1..size, kept as a tree of removed counts.
// Input channel (in_valid_i/in_ready_o) takes one word: func_i = 0 refills all
// positions 1..min(active size, MaxPositions); func_i = 1 selects the rank_i-th
// present position in ascending order and removes it. Each word gives exactly one
// result word on the output channel: position, error flag, remaining count.
// A rank of zero or above the remaining count sets error_o and changes nothing.
// The config channel (cfg_valid_i/cfg_ready_o) writes the active size; it only
// takes effect at the next refill. It is always ready.
// A select runs one tree level per cycle through the node memory, from the root
// down to a leaf, then gives its result; a bad rank skips the walk. A refill clears
// the node memory one entry a cycle, all 2*2^ceil(log2(MaxPositions)) entries,
// and then gives its result.
// Words are handled one at a time; in_ready_o is high only when no word is in work.
// After reset the same clearing pass runs with in_ready_o low, and no result is
// produced for it.
// A stalled receiver holds the result in the output register; the next word is
// still accepted and worked on, and waits for the register to empty.
module rank_select_and_remove_unit #(
  parameter int MaxPositions = rsr_pkg::MAX_POSITIONS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rsr_pkg::DATA_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [rsr_pkg::DATA_W-1:0] rank_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rsr_pkg::DATA_W-1:0] position_o,
  output logic                      error_o,
  output logic [rsr_pkg::DATA_W-1:0] remaining_o
);
  import rsr_pkg::*;

  rsr_cmd_t    cmd;
  rsr_status_t status;

  assign cfg_ready_o = 1'b1;

  rsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rsr_datapath #(
    .MaxPositions (MaxPositions)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rank_i      (rank_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .position_o  (position_o),
    .error_o     (error_o),
    .remaining_o (remaining_o)
  );

endmodule

// ----- verif/rank_select_and_remove_unit_tb.sv -----
module rank_select_and_remove_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW   = rsr_pkg::DATA_W;
  localparam int NPOS = rsr_pkg::MAX_POSITIONS_DEF;

  localparam logic FUNC_REFILL = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  localparam logic [DW-1:0] RANK_MAX = '1;

  typedef struct packed {
    logic          func;
    logic [DW-1:0] rank;
  } select_word_t;

  typedef struct packed {
    logic [DW-1:0] position;
    logic          error;
    logic [DW-1:0] remaining;
  } removal_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [DW-1:0] cfg_data_i  = '0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic          func_i      = FUNC_REFILL;
  logic [DW-1:0] rank_i      = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [DW-1:0] position_o;
  logic          error_o;
  logic [DW-1:0] remaining_o;

  rank_select_and_remove_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .error_o     (error_o),
    .remaining_o (remaining_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  select_word_t word_backlog[$];
  removal_t     awaited_removals[$];

  int unsigned send_idle_pct  = 7;
  int unsigned recv_stall_pct = 59;
  int unsigned fail_count     = 0;
  int unsigned n_checked      = 0;
  int unsigned n_refills      = 0;
  int unsigned n_removals     = 0;
  int unsigned n_rejects      = 0;

  // shadow of the block: presence map over positions, live count, size register
  bit            present_map [1:NPOS];
  int unsigned   live_count;
  logic [DW-1:0] size_setting;

  // stimulus-side bookkeeping, only used to steer ranks toward valid ones
  int unsigned   gen_size = rsr_pkg::ACTIVE_RESET;
  int unsigned   gen_left = rsr_pkg::ACTIVE_RESET;

  function automatic void refill_map();
    int unsigned sz;
    sz = (size_setting > NPOS) ? NPOS : size_setting;
    for (int p = 1; p <= NPOS; p++) present_map[p] = (p <= sz);
    live_count = sz;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_words
    select_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_backlog.pop_front();
        in_valid_i <= 1'b1;
        func_i     <= w.func;
        rank_i     <= w.rank;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // predictor: runs on every accepted word and config write
  always @(posedge clk_i) begin : predict_removals
    removal_t    want;
    int unsigned seen;
    if (!rst_ni) begin
      size_setting = DW'(rsr_pkg::ACTIVE_RESET);
      refill_map();
    end else begin
      if (cfg_valid_i && cfg_ready_o) size_setting = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        want = '0;
        if (func_i == FUNC_REFILL) begin
          refill_map();
          n_refills++;
        end else if (rank_i == 0 || rank_i > live_count) begin
          want.error = 1'b1;
          n_rejects++;
        end else begin
          seen = 0;
          for (int p = 1; p <= NPOS; p++) begin
            if (present_map[p]) begin
              seen++;
              if (seen == rank_i) begin
                want.position  = DW'(p);
                present_map[p] = 1'b0;
                break;
              end
            end
          end
          live_count--;
          n_removals++;
        end
        want.remaining = DW'(live_count);
        awaited_removals.push_back(want);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_removals
    removal_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_removals.size() == 0) begin
        $error("unexpected result word: position %0d error %0d remaining %0d",
               position_o, error_o, remaining_o);
        fail_count++;
      end else begin
        want = awaited_removals.pop_front();
        n_checked++;
        if (position_o !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position_o);
          fail_count++;
        end
        if (error_o !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, error_o);
          fail_count++;
        end
        if (remaining_o !== want.remaining) begin
          $error("remaining: expected %0d, got %0d", want.remaining, remaining_o);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_word(logic func, logic [DW-1:0] rank);
    select_word_t w;
    w.func = func;
    w.rank = rank;
    word_backlog.push_back(w);
    if (func == FUNC_REFILL) gen_left = (gen_size > NPOS) ? NPOS : gen_size;
    else if (rank != 0 && rank <= gen_left) gen_left--;
  endtask

  // every word gives a result, so an empty expectation queue means the block is idle;
  // sampled mid-cycle so the edge's updates have all landed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (word_backlog.size() != 0 || in_valid_i || awaited_removals.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_size(logic [DW-1:0] sz);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gen_size = sz;
  endtask

  task automatic random_sessions(int unsigned target);
    int unsigned made;
    int unsigned n;
    int unsigned p;
    logic [DW-1:0] sz;
    made = 0;
    while (made < target) begin
      p = $urandom_range(99);
      if (p < 60)      sz = DW'($urandom_range(1, 16));
      else if (p < 80) sz = DW'($urandom_range(17, 300));
      else if (p < 88) sz = DW'(NPOS);
      else if (p < 92) sz = '0;
      else if (p < 96) sz = DW'($urandom_range(NPOS + 1, 2047));
      else             sz = DW'($urandom_range(301, NPOS - 1));
      set_size(sz);
      queue_word(FUNC_REFILL, DW'($urandom_range(2047)));
      n = (gen_left < 40) ? gen_left + $urandom_range(0, 3) : $urandom_range(20, 40);
      for (int i = 0; i < n; i++) begin
        p = $urandom_range(99);
        if (p < 82 && gen_left > 0) queue_word(FUNC_SELECT, DW'($urandom_range(1, gen_left)));
        else if (p < 86)            queue_word(FUNC_SELECT, '0);
        else if (p < 90)            queue_word(FUNC_SELECT, DW'(gen_left + 1));
        else if (p < 94)            queue_word(FUNC_SELECT, DW'($urandom_range(2047)));
        else if (p < 97)            queue_word(FUNC_SELECT, RANK_MAX);
        else                        queue_word(FUNC_REFILL, DW'($urandom_range(2047)));
      end
      made += n + 1;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // after reset the set is 1..1024
    queue_word(FUNC_SELECT, '0);
    queue_word(FUNC_SELECT, DW'(NPOS + 1));
    queue_word(FUNC_SELECT, RANK_MAX);
    queue_word(FUNC_SELECT, DW'(NPOS));
    queue_word(FUNC_SELECT, DW'(1));
    queue_word(FUNC_SELECT, DW'(NPOS - 2));
    queue_word(FUNC_SELECT, DW'(512));
    queue_word(FUNC_REFILL, RANK_MAX);  // rank ignored on refill
    queue_word(FUNC_SELECT, DW'(NPOS));
    // empty set
    set_size('0);
    queue_word(FUNC_REFILL, '0);
    queue_word(FUNC_SELECT, DW'(1));
    queue_word(FUNC_SELECT, '0);
    // oversized size saturates
    set_size(RANK_MAX);
    queue_word(FUNC_REFILL, '0);
    queue_word(FUNC_SELECT, DW'(NPOS));
    queue_word(FUNC_SELECT, DW'(NPOS - 1));
    // single position, then exhausted
    set_size(DW'(1));
    queue_word(FUNC_REFILL, '0);
    queue_word(FUNC_SELECT, DW'(1));
    queue_word(FUNC_SELECT, DW'(1));
    set_size(DW'(2));
    queue_word(FUNC_REFILL, DW'(5));
    queue_word(FUNC_SELECT, DW'(2));
    queue_word(FUNC_SELECT, DW'(1));
    queue_word(FUNC_SELECT, DW'(1));

    random_sessions(160);
    wait_idle();
    send_idle_pct  = 59;
    recv_stall_pct = 7;
    random_sessions(160);
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_sessions(160);

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("checked %0d result words: %0d refills, %0d removals, %0d rejected ranks",
             n_checked, n_refills, n_removals, n_rejects);
    $display("sizes from empty to oversized, idling on input, output and neither side");
    if (fail_count == 0) begin
      $display("** rank_select_and_remove_unit: PASSED **");
    end else begin
      $display("** rank_select_and_remove_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for result words");
    $display("** rank_select_and_remove_unit: FAILED **");
    $finish;
  end

endmodule

// ----- rank_select_and_remove_unit.f -----
sv/rsr_pkg.sv
sv/rsr_datapath.sv
sv/rsr_ctrl.sv
sv/rank_select_and_remove_unit.sv
verif/rank_select_and_remove_unit_tb.sv
